>>> design/imh_pkg.sv
package imh_pkg;

  // Fixed field widths of the command and result transactions.
  localparam int CMD_W  = 2;
  localparam int ID_W   = 10;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 16;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 9;

  // Defaults for the top-level parameters.
  localparam int DEF_CAPACITY     = 256;
  localparam int DEF_ID_SPACE     = 1024;
  localparam int DEF_PAYLOAD_BITS = 16;

  // Reset value of the capacity register.
  localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_CHANGE = 2'd1,
    CMD_DELMIN = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [ID_W-1:0]        out_id;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]       out_payload;
  } result_t;

endpackage

>>> design/imh_if.sv
// Command channel: one transaction carries one heap command.
interface imh_in_if import imh_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [ID_W-1:0]         item_id;
  logic signed [KEY_W-1:0] item_key;
  logic [PAY_W-1:0]        item_payload;

  modport source (output valid, cmd, item_id, item_key, item_payload, input ready);
  modport sink (input valid, cmd, item_id, item_key, item_payload, output ready);
endinterface

// Result channel: one transaction per command.
interface imh_out_if import imh_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [ID_W-1:0]         out_id;
  logic signed [KEY_W-1:0] out_key;
  logic [PAY_W-1:0]        out_payload;

  modport source (output valid, status, out_id, out_key, out_payload, input ready);
  modport sink (input valid, status, out_id, out_key, out_payload, output ready);
endinterface

>>> design/indexed_min_heap_core.sv
// Indexed binary min-heap. Each command transaction yields exactly one result
// transaction. After reset the block first clears its id-to-slot map, one
// entry a cycle, so the command channel is not ready until all ID_SPACE
// entries (1024 by default) are cleared. A command then takes a lookup plus the
// sift walk through the heap memory: each level moved up reads the parent
// and then compares and writes back, and each level examined on the way down
// reads the left child, then the right child, then compares and writes back.
// One command is in work at a time; the output register lets the next
// command start while a result still waits to be taken. capacity_in_use
// may only be written while idle.
module indexed_min_heap_core import imh_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int ID_SPACE     = DEF_ID_SPACE,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  imh_in_if.sink           in_ch,
  imh_out_if.source        out_ch
);

  logic [CFG_W-1:0] capacity_in_use;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_in_use <= cfg_wdata;
    end
  end

  imh_ctrl #(
    .CAPACITY     (CAPACITY),
    .ID_SPACE     (ID_SPACE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .capacity_in_use (capacity_in_use),
    .in_ch           (in_ch),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (res_ready) begin
      out_ch.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_ch.status      <= res.status;
      out_ch.out_id      <= res.out_id;
      out_ch.out_key     <= res.out_key;
      out_ch.out_payload <= res.out_payload;
    end
  end

endmodule

>>> design/imh_ctrl.sv
module imh_ctrl import imh_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int ID_SPACE     = DEF_ID_SPACE,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] capacity_in_use,
  imh_in_if.sink           in_ch,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int SW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(ID_SPACE);
  localparam int LW = (SW > CFG_W) ? SW : CFG_W;
  localparam int XW = (ID_W > IW) ? ID_W + 1 : IW + 1;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         id;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  typedef enum logic [12:0] {
    S_CLR    = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_POS_RD = 13'b0000000000100,
    S_TK_RD  = 13'b0000000001000,
    S_TK_CAP = 13'b0000000010000,
    S_CH_CAP = 13'b0000000100000,
    S_UP_RD  = 13'b0000001000000,
    S_UP_CMP = 13'b0000010000000,
    S_DN_L   = 13'b0000100000000,
    S_DN_R   = 13'b0001000000000,
    S_DN_C   = 13'b0010000000000,
    S_PLACE  = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // Heap and position memories, with registered reads.
  entry_t        heap_mem [0:CAPACITY];
  logic [SW-1:0] pos_mem  [0:ID_SPACE-1];

  entry_t        h_rdata;
  logic [SW-1:0] h_raddr;
  logic          h_we;
  logic [SW-1:0] h_waddr;
  entry_t        h_wdata;

  logic [SW-1:0] p_rdata;
  logic          p_we;
  logic [IW-1:0] p_waddr;
  logic [SW-1:0] p_wdata;

  // Working registers.
  logic [IW-1:0]           clr_idx;
  logic [CMD_W-1:0]        cmd;
  logic [ID_W-1:0]         id;
  logic signed [KEY_W-1:0] key;
  logic [PAYLOAD_BITS-1:0] pay;
  logic [SW-1:0]           count;
  logic [SW-1:0]           idx;
  entry_t                  ent;
  entry_t                  left;
  entry_t                  rem;
  logic [STAT_W-1:0]       status;

  logic [SW:0]   lidx;
  logic [SW:0]   ridx;
  logic          has_r;
  logic          pick_r;
  entry_t        child;
  logic [SW-1:0] child_idx;
  logic          full;
  logic          id_ok;

  always_comb begin
    lidx      = {idx, 1'b0};
    ridx      = lidx + 1'b1;
    has_r     = ridx <= {1'b0, count};
    pick_r    = has_r && (h_rdata.key < left.key);
    child     = pick_r ? h_rdata : left;
    child_idx = pick_r ? ridx[SW-1:0] : lidx[SW-1:0];
    full      = (count >= SW'(CAPACITY)) || (LW'(count) >= LW'(capacity_in_use));
    id_ok     = XW'(in_ch.item_id) < XW'(ID_SPACE);
  end

  // Heap read address follows the step being taken. A missing right child
  // rereads the left one so the address stays inside the memory.
  always_comb begin
    case (state)
      S_POS_RD: h_raddr = p_rdata;
      S_TK_RD:  h_raddr = count;
      S_UP_RD:  h_raddr = idx >> 1;
      S_DN_L:   h_raddr = lidx[SW-1:0];
      S_DN_R:   h_raddr = has_r ? ridx[SW-1:0] : lidx[SW-1:0];
      default:  h_raddr = SW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    h_rdata <= heap_mem[h_raddr];
    if (h_we) begin
      heap_mem[h_waddr] <= h_wdata;
    end
  end

  always_ff @(posedge clk) begin
    p_rdata <= pos_mem[IW'(in_ch.item_id)];
    if (p_we) begin
      pos_mem[p_waddr] <= p_wdata;
    end
  end

  // Memory writes: the clearing pass, clearing a taken item's map entry, moves during sifting and final placement.
  always_comb begin
    h_we    = 1'b0;
    h_waddr = idx;
    h_wdata = ent;
    p_we    = 1'b0;
    p_waddr = IW'(ent.id);
    p_wdata = idx;
    case (state)
      S_CLR: begin
        p_we    = 1'b1;
        p_waddr = clr_idx;
        p_wdata = '0;
      end
      S_TK_CAP: begin
        p_we    = 1'b1;
        p_waddr = IW'(rem.id);
        p_wdata = '0;
      end
      S_UP_CMP: begin
        if (ent.key < h_rdata.key) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_waddr = IW'(h_rdata.id);
        end
      end
      S_DN_C: begin
        if (child.key < ent.key) begin
          h_we    = 1'b1;
          h_wdata = child;
          p_we    = 1'b1;
          p_waddr = IW'(child.id);
        end
      end
      S_PLACE: begin
        h_we = 1'b1;
        p_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:    if (clr_idx == IW'(ID_SPACE - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.cmd == CMD_DELMIN) begin
            state_next = (count == '0) ? S_FIN : S_TK_RD;
          end else begin
            state_next = id_ok ? S_POS_RD : S_FIN;
          end
        end
      end
      S_POS_RD: begin
        if (cmd == CMD_INSERT) begin
          state_next = (full || p_rdata != '0) ? S_FIN : S_UP_RD;
        end else if (p_rdata == '0 || p_rdata > count) begin
          state_next = S_FIN;
        end else if (cmd == CMD_CHANGE) begin
          state_next = S_CH_CAP;
        end else begin
          state_next = S_TK_RD;
        end
      end
      S_TK_RD:  state_next = S_TK_CAP;
      S_TK_CAP: state_next = (idx < count) ? S_UP_RD : S_FIN;
      S_CH_CAP: state_next = S_UP_RD;
      S_UP_RD:  state_next = (idx == SW'(1)) ? S_DN_L : S_UP_CMP;
      S_UP_CMP: state_next = (ent.key < h_rdata.key) ? S_UP_RD : S_DN_L;
      S_DN_L:   state_next = (lidx > {1'b0, count}) ? S_PLACE : S_DN_R;
      S_DN_R:   state_next = S_DN_C;
      S_DN_C:   state_next = (child.key < ent.key) ? S_DN_L : S_PLACE;
      S_PLACE:  state_next = S_FIN;
      S_FIN:    if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
      count   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == S_POS_RD && cmd == CMD_INSERT && !full && p_rdata == '0) begin
        count <= count + 1'b1;
      end
      if (state == S_TK_CAP) begin
        count <= count - 1'b1;
      end
    end
  end

  // Working data and the result fields.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd    <= in_ch.cmd;
        id     <= in_ch.item_id;
        key    <= in_ch.item_key;
        pay    <= PAYLOAD_BITS'(in_ch.item_payload);
        idx    <= SW'(1);
        rem    <= '0;
        status <= ST_OK;
        if (in_ch.cmd == CMD_DELMIN) begin
          if (count == '0) status <= ST_EMPTY;
        end else if (!id_ok) begin
          status <= ST_NOT_FOUND;
        end
      end
      S_POS_RD: begin
        if (cmd == CMD_INSERT) begin
          ent <= '{key: key, id: id, pay: pay};
          idx <= count + 1'b1;
          if (full) begin
            status <= ST_FULL;
          end else if (p_rdata != '0) begin
            status <= ST_DUPLICATE;
          end
        end else begin
          idx <= p_rdata;
          if (p_rdata == '0 || p_rdata > count) status <= ST_NOT_FOUND;
        end
      end
      S_TK_RD:  rem <= h_rdata;
      S_TK_CAP: ent <= h_rdata;
      S_CH_CAP: ent <= '{key: key, id: h_rdata.id, pay: h_rdata.pay};
      S_UP_CMP: if (ent.key < h_rdata.key) idx <= idx >> 1;
      S_DN_R:   left <= h_rdata;
      S_DN_C:   if (child.key < ent.key) idx <= child_idx;
      default: begin
      end
    endcase
  end

  assign in_ch.ready        = (state == S_IDLE);
  assign res_valid          = (state == S_FIN);
  assign res.status         = status;
  assign res.out_id         = rem.id;
  assign res.out_key        = rem.key;
  assign res.out_payload    = PAY_W'(rem.pay);

endmodule

>>> tb/imh_tb_pkg.sv
package imh_tb_pkg;
  import imh_pkg::*;

  // One command as the stimulus and the checker see it.
  typedef struct packed {
    cmd_t                    cmd;
    logic [ID_W-1:0]         id;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } heap_cmd_t;

endpackage

>>> tb/imh_heap_checker.sv
module imh_heap_checker import imh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [ID_W-1:0]  in_id,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [PAY_W-1:0] in_payload,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [STAT_W-1:0] out_status,
  input  logic [ID_W-1:0]  out_id,
  input  logic signed [KEY_W-1:0] out_key,
  input  logic [PAY_W-1:0] out_payload,
  output int               fail_count,
  output int               pending,
  output int               result_count
);
  localparam int CAP = DEF_CAPACITY;
  localparam int IDS = DEF_ID_SPACE;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         id;
    logic [PAY_W-1:0]        pay;
  } slot_t;

  // Shadow copy of the heap and its id map.
  slot_t    shadow_heap [1:CAP];
  int       shadow_pos [IDS];
  int       shadow_count;
  int       cap_limit;
  result_t  expected_results [$];

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", result_count, what, got, want);
    fail_count++;
  endtask

  function automatic void place(int i, slot_t e);
    shadow_heap[i] = e;
    shadow_pos[e.id] = i;
  endfunction

  function automatic int rise(int i);
    slot_t e;
    e = shadow_heap[i];
    while (i > 1 && e.key < shadow_heap[i/2].key) begin
      place(i, shadow_heap[i/2]);
      i = i / 2;
    end
    place(i, e);
    return i;
  endfunction

  function automatic void sink_down(int i);
    slot_t e;
    int c;
    e = shadow_heap[i];
    forever begin
      if (2*i > shadow_count) break;
      c = 2*i;
      if (c + 1 <= shadow_count && shadow_heap[c+1].key < shadow_heap[c].key) c = c + 1;
      if (!(shadow_heap[c].key < e.key)) break;
      place(i, shadow_heap[c]);
      i = c;
    end
    place(i, e);
  endfunction

  function automatic slot_t extract(int p);
    slot_t e, last;
    e = shadow_heap[p];
    last = shadow_heap[shadow_count];
    shadow_pos[e.id] = 0;
    shadow_count--;
    if (p <= shadow_count) begin
      place(p, last);
      sink_down(rise(p));
    end
    return e;
  endfunction

  // Apply one command to the shadow heap and return its result.
  function automatic result_t heap_predict(logic [CMD_W-1:0] c, int id,
                                           logic signed [KEY_W-1:0] key,
                                           logic [PAY_W-1:0] pay);
    result_t r;
    slot_t e;
    int p;
    r = '0;
    r.status = ST_OK;
    if (c == CMD_DELMIN) begin
      if (shadow_count == 0) r.status = ST_EMPTY;
      else begin
        e = extract(1);
        r.out_id = e.id; r.out_key = e.key; r.out_payload = e.pay;
      end
    end else if (c == CMD_INSERT) begin
      if (shadow_count >= cap_limit) r.status = ST_FULL;
      else if (shadow_pos[id] != 0) r.status = ST_DUPLICATE;
      else begin
        e.key = key; e.id = ID_W'(id); e.pay = pay;
        shadow_count++;
        place(shadow_count, e);
        void'(rise(shadow_count));
      end
    end else if (shadow_pos[id] == 0 || shadow_pos[id] > shadow_count) begin
      r.status = ST_NOT_FOUND;
    end else if (c == CMD_CHANGE) begin
      p = shadow_pos[id];
      shadow_heap[p].key = key;
      sink_down(rise(p));
    end else begin
      e = extract(shadow_pos[id]);
      r.out_id = e.id; r.out_key = e.key; r.out_payload = e.pay;
    end
    return r;
  endfunction

  // Track configuration, predict on accepted commands, compare accepted results.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (shadow_pos[i]) shadow_pos[i] = 0;
      shadow_count = 0;
      cap_limit = CAP;
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_we) cap_limit = (cfg_wdata < CAP) ? cfg_wdata : CAP;
      if (in_valid && in_ready)
        expected_results.push_back(heap_predict(in_cmd, in_id, in_key, in_payload));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("outstanding commands", 0, 1);
        end else begin
          want = expected_results.pop_front();
          if (out_status != want.status) report_mismatch("status", out_status, want.status);
          if (out_id != want.out_id) report_mismatch("out_id", out_id, want.out_id);
          if (out_key != want.out_key) report_mismatch("out_key", out_key, want.out_key);
          if (out_payload != want.out_payload)
            report_mismatch("out_payload", out_payload, want.out_payload);
        end
        result_count++;
      end
    end
    pending = expected_results.size();
  end
endmodule

>>> tb/imh_tb_if.sv
// Interfaces come from the design; this file only holds the bench defaults.
package imh_tb_defaults;
  localparam int IDLE_PCT = 29;
endpackage

>>> tb/tb.sv
module tb;
  import imh_pkg::*;
  import imh_tb_pkg::*;
  import imh_tb_defaults::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int fail_count, pending, result_count;
  int sent;
  bit sink_hold, quiet;

  imh_in_if  in_ch ();
  imh_out_if out_ch ();

  indexed_min_heap_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  imh_heap_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
    .in_id(in_ch.item_id), .in_key(in_ch.item_key), .in_payload(in_ch.item_payload),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
    .out_id(out_ch.out_id), .out_key(out_ch.out_key), .out_payload(out_ch.out_payload),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !sink_hold && (quiet || $urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    sink_hold = 1'b0;
    wait (sent == 60);
    sink_hold = 1'b1;
    repeat (300) @(posedge clk);
    sink_hold = 1'b0;
  end

  // Offer one command and hold it until the block takes it.
  task automatic send_cmd(heap_cmd_t c);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      @(posedge clk);
      in_ch.valid <= 1'b0;
    end
    @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c.cmd;
    in_ch.item_id <= c.id;
    in_ch.item_key <= c.key;
    in_ch.item_payload <= c.payload;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    sent++;
  endtask

  task automatic send(cmd_t op, int id, logic [KEY_W-1:0] key, int pay);
    heap_cmd_t c;
    c.cmd = op; c.id = ID_W'(id); c.key = key; c.payload = PAY_W'(pay);
    send_cmd(c);
  endtask

  // Let every expected result arrive, then give the block time to settle.
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_capacity(int value);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random commands over an id pool of the given size; a small pool makes hits common.
  task automatic random_phase(int count, int id_pool);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40) send(CMD_INSERT, $urandom_range(id_pool), $urandom, $urandom);
      else if (r < 60) send(CMD_CHANGE, $urandom_range(id_pool), $urandom, $urandom);
      else if (r < 80) send(CMD_DELMIN, $urandom, $urandom, $urandom);
      else if (r < 95) send(CMD_REMOVE, $urandom_range(id_pool), $urandom, $urandom);
      else send(cmd_t'($urandom_range(3)), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.item_id = '0;
    in_ch.item_key = '0;
    in_ch.item_payload = '0;
    sent = 0;
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, all commands, errors and ties.
    send(CMD_DELMIN, 0, 0, 0);
    send(CMD_INSERT, 1023, 32'h7fffffff, 16'hffff);
    send(CMD_INSERT, 0, 32'h80000000, 0);
    send(CMD_INSERT, 5, 32'h80000000, 16'h1234);
    send(CMD_INSERT, 1023, 0, 0);
    send(CMD_INSERT, 7, 0, 16'h5555);
    send(CMD_CHANGE, 7, 32'hffffffff, 16'haaaa);
    send(CMD_CHANGE, 1023, 32'h80000001, 0);
    send(CMD_CHANGE, 9, 3, 0);
    send(CMD_REMOVE, 9, 0, 0);
    send(CMD_REMOVE, 5, 0, 0);
    send(CMD_DELMIN, 0, 0, 0);
    send(CMD_DELMIN, 0, 0, 0);
    send(CMD_DELMIN, 0, 0, 0);
    send(CMD_DELMIN, 0, 0, 0);
    set_capacity(1);
    send(CMD_INSERT, 3, 1, 1);
    send(CMD_INSERT, 4, 2, 2);
    set_capacity(0);
    send(CMD_INSERT, 4, 2, 2);
    send(CMD_REMOVE, 3, 0, 0);
    set_capacity(511);

    // Random phases across capacity settings, with a quiet stretch.
    random_phase(120, 63);
    quiet = 1'b1;
    random_phase(60, 31);
    quiet = 1'b0;
    set_capacity(3);
    random_phase(50, 7);
    set_capacity(256);
    for (int i = 0; i < 40; i++) send(CMD_INSERT, $urandom_range(1023), $urandom, $urandom);
    random_phase(120, 1023);
    set_capacity(20);
    random_phase(40, 40);
    drain();
    $display("covered %0d commands and %0d results over capacities 0, 1, 3, 20, 256 and 511",
             sent, result_count);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

>>> files.f
design/imh_pkg.sv
design/imh_if.sv
design/imh_ctrl.sv
design/indexed_min_heap_core.sv
tb/imh_tb_pkg.sv
tb/imh_heap_checker.sv
tb/imh_tb_if.sv
tb/tb.sv
